// ----- rtl/cgs_pkg.sv -----
// ----------------------------------------------------------------------------
// Conjugate gradient solver package
// Shared sizes, item codes and fixed-point helpers for the solver.
// ----------------------------------------------------------------------------
`default_nettype none

package cgs_pkg;

   localparam int N_MAX     = 16;
   localparam int FRAC_BITS = 16;
   localparam int IDX_W     = $clog2(N_MAX);
   localparam int ADDR_W    = 2 * IDX_W;
   localparam int VAL_W     = 32;
   localparam int ACC_W     = 64;

   localparam logic [1:0] FUNC_MATRIX = 2'd0;
   localparam logic [1:0] FUNC_RHS    = 2'd1;
   localparam logic [1:0] FUNC_SOLVE  = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EARLY = 2'd1;
   localparam logic [1:0] STATUS_SAT   = 2'd2;

   localparam logic signed [ACC_W-1:0] LIM_HI = 64'sd2147483647;
   localparam logic signed [ACC_W-1:0] LIM_LO = -64'sd2147483648;

   typedef struct packed {
      logic                    sat;
      logic signed [VAL_W-1:0] val;
   } clamp_type;

   // Limits a wide value to the 32-bit range and reports whether it had to.
   function automatic clamp_type fx_clamp(input logic signed [ACC_W-1:0] v);
      clamp_type res;
      res.sat = 1'b0;
      res.val = v[VAL_W-1:0];
      if (v > LIM_HI) begin
         res.sat = 1'b1;
         res.val = LIM_HI[VAL_W-1:0];
      end else if (v < LIM_LO) begin
         res.sat = 1'b1;
         res.val = LIM_LO[VAL_W-1:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/conjugate_gradient_solver_unit.sv -----
// ----------------------------------------------------------------------------
// Conjugate gradient solver unit
// Loads a matrix and right-hand side, then solves A x = b in fixed point.
// ----------------------------------------------------------------------------
// Usage: items arrive on the req_ channel. A matrix or right-hand-side load
// item is written in the cycle it is accepted and the block is ready again
// in the next cycle, so loads stream at one item per cycle. A solve item
// runs n conjugate gradient iterations (n from the csr_ size register, 0
// acting as 1 and values above 16 as 16), then emits n result items on the
// rsp_ channel, element 0 first, with last set on element n-1.
// A full solve is paced by the single 32x32 multiplier, which every
// matrix-vector product, dot product and vector update passes through one
// element at a time, and by the bit-serial divider, whose quotient steps are
// skipped when the quotient saturates; an early stop ends the solve sooner.
// Each result item is registered, then held until it is taken. The block
// accepts no item while a solve runs or its results are being delivered.
// If the receiver stalls, the pending result simply holds on the rsp_ ports.
// Reset (synchronous, active high) returns the block to idle with the size
// register at 16; stored matrix and vector entries are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module conjugate_gradient_solver_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_ready,
   input  wire logic [1:0]                         req_func,
   input  wire logic [cgs_pkg::IDX_W-1:0]          req_row,
   input  wire logic [cgs_pkg::IDX_W-1:0]          req_col,
   input  wire logic signed [cgs_pkg::VAL_W-1:0]   req_value,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   output      logic [cgs_pkg::IDX_W-1:0]          rsp_index,
   output      logic signed [cgs_pkg::VAL_W-1:0]   rsp_solution,
   output      logic                               rsp_last,
   output      logic [1:0]                         rsp_status,
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [4:0]                         csr_data
);

   typedef enum logic [4:0] {
      S_IDLE, S_INIT, S_AZ_RD, S_AZ_MUL, S_AZ_ACC, S_AZ_STORE,
      S_DOT_MUL, S_DOT_ACC, S_DIV_PREP, S_DIV_CHK, S_DIV_RUN, S_DIV_END,
      S_UPD_X_MUL, S_UPD_X, S_UPD_R_MUL, S_UPD_R, S_DIR_MUL, S_DIR_WR,
      S_EMIT, S_OUT
   } state_type;

   typedef enum logic [1:0] {DOT_ZAZ, DOT_RR, DOT_RRNEW} dot_type;

   state_type state_ff;
   dot_type   dot_ff;

   logic [4:0]                           size_ff;
   logic [cgs_pkg::IDX_W-1:0]            n_last;
   logic [cgs_pkg::IDX_W-1:0]            idx_ff, row_ff, it_ff;
   logic signed [cgs_pkg::VAL_W-1:0]     rhs_ff [cgs_pkg::N_MAX];
   logic signed [cgs_pkg::VAL_W-1:0]     x_ff [cgs_pkg::N_MAX];
   logic signed [cgs_pkg::VAL_W-1:0]     r_ff [cgs_pkg::N_MAX];
   logic signed [cgs_pkg::VAL_W-1:0]     z_ff [cgs_pkg::N_MAX];
   logic signed [cgs_pkg::VAL_W-1:0]     p_ff [cgs_pkg::N_MAX];
   logic signed [cgs_pkg::VAL_W-1:0]     coef_ff;
   logic signed [cgs_pkg::ACC_W-1:0]     prod_ff, acc_ff, zaz_ff, rr_ff;
   logic signed [cgs_pkg::ACC_W-1:0]     num_ff, den_ff;
   logic [cgs_pkg::ACC_W-1:0]            un_ff, ud_ff, rem_ff;
   logic [30:0]                          q_ff;
   logic [4:0]                           k_ff;
   logic                                 neg_ff, sat_ff;
   logic [1:0]                           status_ff;

   logic                                 rsp_valid_ff, rsp_last_ff;
   logic [cgs_pkg::IDX_W-1:0]            rsp_index_ff;
   logic signed [cgs_pkg::VAL_W-1:0]     rsp_solution_ff;
   logic [1:0]                           rsp_status_ff;

   logic [cgs_pkg::VAL_W-1:0]            ram_rdata;
   logic                                 ram_wr;

   logic signed [cgs_pkg::VAL_W-1:0]     mul_a, mul_b;
   logic signed [cgs_pkg::ACC_W-1:0]     sh, acc_sum;
   cgs_pkg::clamp_type                   cl_az, cl_x, cl_r, cl_z;
   logic [78:0]                          big_den, big_num;
   logic [64:0]                          rem2, ud65;
   logic                                 dbit;
   logic [cgs_pkg::VAL_W-1:0]            mag;

   // Effective dimension: zero acts as one, oversize as the maximum.
   always_comb begin
      if (size_ff == 5'd0) begin
         n_last = '0;
      end else if (size_ff > 5'(cgs_pkg::N_MAX)) begin
         n_last = cgs_pkg::IDX_W'(cgs_pkg::N_MAX - 1);
      end else begin
         n_last = cgs_pkg::IDX_W'(size_ff - 5'd1);
      end
   end

   assign req_ready    = (state_ff == S_IDLE);
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_index    = rsp_index_ff;
   assign rsp_solution = rsp_solution_ff;
   assign rsp_last     = rsp_last_ff;
   assign rsp_status   = rsp_status_ff;

   assign ram_wr = req_valid && req_ready && (req_func == cgs_pkg::FUNC_MATRIX);

   cgs_ram #(
      .WIDTH (cgs_pkg::VAL_W),
      .DEPTH (cgs_pkg::N_MAX * cgs_pkg::N_MAX)
   ) u_matrix (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr ({req_row, req_col}),
      .wr_data (req_value),
      .rd_addr ({row_ff, idx_ff}),
      .rd_data (ram_rdata)
   );

   // The one shared multiplier: its operands are chosen by the step in hand.
   always_comb begin
      unique case (state_ff)
         S_AZ_MUL: begin
            mul_a = ram_rdata;
            mul_b = z_ff[idx_ff];
         end
         S_DOT_MUL: begin
            mul_a = (dot_ff == DOT_ZAZ) ? z_ff[idx_ff] : r_ff[idx_ff];
            mul_b = (dot_ff == DOT_ZAZ) ? p_ff[idx_ff] : r_ff[idx_ff];
         end
         S_UPD_X_MUL, S_DIR_MUL: begin
            mul_a = coef_ff;
            mul_b = z_ff[idx_ff];
         end
         S_UPD_R_MUL: begin
            mul_a = coef_ff;
            mul_b = p_ff[idx_ff];
         end
         default: begin
            mul_a = r_ff[idx_ff];
            mul_b = r_ff[idx_ff];
         end
      endcase
   end

   assign sh      = prod_ff >>> cgs_pkg::FRAC_BITS;
   assign acc_sum = acc_ff + sh;
   assign cl_az   = cgs_pkg::fx_clamp(acc_ff);
   assign cl_x    = cgs_pkg::fx_clamp({{32{x_ff[idx_ff][31]}}, x_ff[idx_ff]} + sh);
   assign cl_r    = cgs_pkg::fx_clamp({{32{r_ff[idx_ff][31]}}, r_ff[idx_ff]} - sh);
   assign cl_z    = cgs_pkg::fx_clamp({{32{r_ff[idx_ff][31]}}, r_ff[idx_ff]} + sh);

   // Divider: the integer part saturates when un >= ud * 2^15; otherwise the
   // 31 quotient bits of (un << 16) / ud come out one per cycle.
   assign big_den = {ud_ff, 15'd0};
   assign big_num = {15'd0, un_ff};
   assign dbit    = k_ff[4] & un_ff[{2'b00, k_ff[3:0]}];
   assign rem2    = {rem_ff, dbit};
   assign ud65    = {1'b0, ud_ff};
   assign mag     = {1'b0, q_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         size_ff      <= 5'(cgs_pkg::N_MAX);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            size_ff <= csr_data;
         end
         prod_ff <= 64'(mul_a * mul_b);
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  if (req_func == cgs_pkg::FUNC_RHS) begin
                     rhs_ff[req_row] <= req_value;
                  end
                  if (req_func == cgs_pkg::FUNC_SOLVE) begin
                     state_ff <= S_INIT;
                  end
               end
            end
            S_INIT: begin
               for (int i = 0; i < cgs_pkg::N_MAX; i++) begin
                  x_ff[i] <= '0;
                  r_ff[i] <= rhs_ff[i];
                  z_ff[i] <= rhs_ff[i];
               end
               sat_ff   <= 1'b0;
               it_ff    <= '0;
               row_ff   <= '0;
               idx_ff   <= '0;
               acc_ff   <= '0;
               state_ff <= S_AZ_RD;
            end
            S_AZ_RD: begin
               state_ff <= S_AZ_MUL;
            end
            S_AZ_MUL: begin
               state_ff <= S_AZ_ACC;
            end
            S_AZ_ACC: begin
               acc_ff <= acc_sum;
               if (idx_ff == n_last) begin
                  state_ff <= S_AZ_STORE;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_AZ_RD;
               end
            end
            S_AZ_STORE: begin
               p_ff[row_ff] <= cl_az.val;
               sat_ff       <= sat_ff | cl_az.sat;
               acc_ff       <= '0;
               idx_ff       <= '0;
               if (row_ff == n_last) begin
                  dot_ff   <= DOT_ZAZ;
                  state_ff <= S_DOT_MUL;
               end else begin
                  row_ff   <= row_ff + 1'b1;
                  state_ff <= S_AZ_RD;
               end
            end
            S_DOT_MUL: begin
               state_ff <= S_DOT_ACC;
            end
            S_DOT_ACC: begin
               if (idx_ff != n_last) begin
                  acc_ff   <= acc_sum;
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_DOT_MUL;
               end else begin
                  acc_ff <= '0;
                  idx_ff <= '0;
                  unique case (dot_ff)
                     DOT_ZAZ: begin
                        if (acc_sum == '0) begin
                           status_ff <= cgs_pkg::STATUS_EARLY;
                           state_ff  <= S_EMIT;
                        end else begin
                           zaz_ff   <= acc_sum;
                           dot_ff   <= DOT_RR;
                           state_ff <= S_DOT_MUL;
                        end
                     end
                     DOT_RR: begin
                        rr_ff    <= acc_sum;
                        num_ff   <= acc_sum;
                        den_ff   <= zaz_ff;
                        state_ff <= S_DIV_PREP;
                     end
                     default: begin
                        num_ff   <= acc_sum;
                        den_ff   <= rr_ff;
                        state_ff <= S_DIV_PREP;
                     end
                  endcase
               end
            end
            S_DIV_PREP: begin
               neg_ff   <= num_ff[63] ^ den_ff[63];
               un_ff    <= num_ff[63] ? 64'(-num_ff) : 64'(num_ff);
               ud_ff    <= den_ff[63] ? 64'(-den_ff) : 64'(den_ff);
               state_ff <= S_DIV_CHK;
            end
            S_DIV_CHK: begin
               if (big_num >= big_den) begin
                  sat_ff   <= 1'b1;
                  coef_ff  <= neg_ff ? cgs_pkg::LIM_LO[31:0] : cgs_pkg::LIM_HI[31:0];
                  state_ff <= (dot_ff == DOT_RR) ? S_UPD_X_MUL : S_DIR_MUL;
               end else begin
                  rem_ff   <= un_ff >> 15;
                  q_ff     <= '0;
                  k_ff     <= 5'd30;
                  state_ff <= S_DIV_RUN;
               end
            end
            S_DIV_RUN: begin
               if (rem2 >= ud65) begin
                  rem_ff <= 64'(rem2 - ud65);
                  q_ff   <= {q_ff[29:0], 1'b1};
               end else begin
                  rem_ff <= rem2[63:0];
                  q_ff   <= {q_ff[29:0], 1'b0};
               end
               k_ff <= k_ff - 1'b1;
               if (k_ff == 5'd0) begin
                  state_ff <= S_DIV_END;
               end
            end
            S_DIV_END: begin
               coef_ff  <= neg_ff ? 32'(-mag) : mag;
               state_ff <= (dot_ff == DOT_RR) ? S_UPD_X_MUL : S_DIR_MUL;
            end
            S_UPD_X_MUL: begin
               state_ff <= S_UPD_X;
            end
            S_UPD_X: begin
               x_ff[idx_ff] <= cl_x.val;
               sat_ff       <= sat_ff | cl_x.sat;
               state_ff     <= S_UPD_R_MUL;
            end
            S_UPD_R_MUL: begin
               state_ff <= S_UPD_R;
            end
            S_UPD_R: begin
               r_ff[idx_ff] <= cl_r.val;
               sat_ff       <= sat_ff | cl_r.sat;
               if (idx_ff != n_last) begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_UPD_X_MUL;
               end else begin
                  idx_ff <= '0;
                  if (rr_ff == '0) begin
                     status_ff <= cgs_pkg::STATUS_EARLY;
                     state_ff  <= S_EMIT;
                  end else begin
                     dot_ff   <= DOT_RRNEW;
                     state_ff <= S_DOT_MUL;
                  end
               end
            end
            S_DIR_MUL: begin
               state_ff <= S_DIR_WR;
            end
            S_DIR_WR: begin
               z_ff[idx_ff] <= cl_z.val;
               if (idx_ff != n_last) begin
                  sat_ff   <= sat_ff | cl_z.sat;
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_DIR_MUL;
               end else begin
                  idx_ff <= '0;
                  row_ff <= '0;
                  if (it_ff == n_last) begin
                     status_ff <= (sat_ff | cl_z.sat) ? cgs_pkg::STATUS_SAT
                                                      : cgs_pkg::STATUS_OK;
                     state_ff  <= S_EMIT;
                  end else begin
                     sat_ff   <= sat_ff | cl_z.sat;
                     it_ff    <= it_ff + 1'b1;
                     state_ff <= S_AZ_RD;
                  end
               end
            end
            S_EMIT: begin
               rsp_valid_ff    <= 1'b1;
               rsp_index_ff    <= idx_ff;
               rsp_solution_ff <= x_ff[idx_ff];
               rsp_last_ff     <= (idx_ff == n_last);
               rsp_status_ff   <= status_ff;
               state_ff        <= S_OUT;
            end
            S_OUT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (rsp_last_ff) begin
                     state_ff <= S_IDLE;
                  end else begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= S_EMIT;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- rtl/cgs_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cgs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire
